/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define FTS_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define FTS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("scheduler check failed");

`endif

/* rtl/fts_pkg.sv */
// types, codes and defaults shared by the scheduler modules
`default_nettype none

package fts_pkg;

    localparam int THREAD_SLOTS_DEF = 16;

    // operation codes of the mode field
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_YIELD  = 2'd1;
    localparam logic [1:0] MODE_SCHED  = 2'd2;
    localparam logic [1:0] MODE_EXIT   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [7:0] target_thread;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] running_thread;
        logic       running_present;
        logic [5:0] previous_thread;
        logic [5:0] created_thread;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DROP_OLD,
        S_DROP_TGT,
        S_APPEND_OLD,
        S_POP,
        S_OUT
    } t_state;

    // which id a queue pass or append works on
    typedef enum logic [1:0] {
        KEY_OLD,
        KEY_TGT,
        KEY_SCAN
    } t_key;

    typedef struct packed {
        logic    capture;
        logic    begin_op;
        logic    set_status;
        t_status status;
        logic    set_prev;
        logic    take_target;
        logic    free_cur;
        logic    scan_step;
        logic    drop;
        t_key    key;
        logic    append;
        logic    pop;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       had;
        logic       present;
        logic       count_zero;
        logic       tgt_range_ok;
        logic       tgt_valid;
        logic       scan_hit;
        logic       scan_last;
        logic       drop_done;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/fifo_thread_scheduler_top.sv */
// round-robin thread scheduler: top level joining controller and datapath
//
// bookkeeping for THREAD_SLOTS thread slots: a valid bit per slot, a fifo
// ready queue of thread ids, the running thread and a rotating allocation
// pointer. each input beat carries one operation (create, yield, schedule,
// exit) and yields exactly one result beat with status, the running thread
// after the operation, the thread switched away from and the created slot.
// one operation is worked at a time; o_stall is high from the beat's
// acceptance until its result has been handed to the output register, and
// the next beat is taken while that result still waits downstream.
// steps per operation: a decode and a result load, and between them
//   create: one slot tested per cycle from the pointer, up to THREAD_SLOTS
//   yield: one or two queue passes, then an append if a thread was running
//   schedule: one pop, then a queue pass and an append when a thread
//          was running; nothing beyond decode when the queue is empty
//   exit: a queue pass when a thread was running, then one pop
// a queue pass rotates the ready queue one entry per cycle; the longest
// operation is a yield with a full queue. no clearing pass after reset:
// the block takes a beat in the first cycle after reset.
`default_nettype none

module fifo_thread_scheduler_top #(
    parameter int THREAD_SLOTS = fts_pkg::THREAD_SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // operation channel
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire fts_pkg::t_in i_data,
    // result channel
    output logic              o_valid,
    input  wire logic         i_stall,
    output fts_pkg::t_out     o_data
);

    // command and status between the sequencer and the datapath
    fts_pkg::t_cmd cmd;
    fts_pkg::t_sts sts;

    // state machine: decode, slot search, queue passes, pop, result load
    fts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // slot bits, ready queue shift line, running thread, result register
    fts_dp #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

/* rtl/fts_ctrl.sv */
// sequencing state machine of the thread scheduler
`default_nettype none

module fts_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  wire logic         i_stall,
    input  wire fts_pkg::t_sts i_sts,
    output fts_pkg::t_cmd     o_cmd
);

    fts_pkg::t_state r_state;
    fts_pkg::t_state n_state;
    logic            r_ovalid;
    logic            n_ovalid;
    logic            out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fts_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fts_pkg::S_IDLE: begin
                if (i_valid) n_state = fts_pkg::S_DECODE;
            end
            fts_pkg::S_DECODE: begin
                case (i_sts.mode)
                    fts_pkg::MODE_CREATE: n_state = fts_pkg::S_SCAN;
                    fts_pkg::MODE_YIELD: begin
                        if (!(i_sts.tgt_range_ok && i_sts.tgt_valid)) begin
                            n_state = fts_pkg::S_OUT;
                        end else if (i_sts.present) begin
                            n_state = fts_pkg::S_DROP_OLD;
                        end else begin
                            n_state = fts_pkg::S_DROP_TGT;
                        end
                    end
                    fts_pkg::MODE_SCHED: begin
                        n_state = i_sts.count_zero ? fts_pkg::S_OUT : fts_pkg::S_POP;
                    end
                    default: begin
                        n_state = i_sts.present ? fts_pkg::S_DROP_OLD : fts_pkg::S_POP;
                    end
                endcase
            end
            fts_pkg::S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_last) n_state = fts_pkg::S_OUT;
            end
            fts_pkg::S_DROP_OLD: begin
                if (i_sts.drop_done) begin
                    case (i_sts.mode)
                        fts_pkg::MODE_YIELD: n_state = fts_pkg::S_DROP_TGT;
                        fts_pkg::MODE_SCHED: n_state = fts_pkg::S_APPEND_OLD;
                        default:             n_state = fts_pkg::S_POP;
                    endcase
                end
            end
            fts_pkg::S_DROP_TGT: begin
                if (i_sts.drop_done) begin
                    n_state = i_sts.had ? fts_pkg::S_APPEND_OLD : fts_pkg::S_OUT;
                end
            end
            fts_pkg::S_APPEND_OLD: n_state = fts_pkg::S_OUT;
            fts_pkg::S_POP: begin
                if (i_sts.mode == fts_pkg::MODE_SCHED && i_sts.had) begin
                    n_state = fts_pkg::S_DROP_OLD;
                end else begin
                    n_state = fts_pkg::S_OUT;
                end
            end
            fts_pkg::S_OUT: begin
                if (out_free) n_state = fts_pkg::S_IDLE;
            end
            default: n_state = fts_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.status = fts_pkg::ST_OK;
        o_cmd.key    = fts_pkg::KEY_OLD;
        case (r_state)
            fts_pkg::S_IDLE: o_cmd.capture = i_valid;
            fts_pkg::S_DECODE: begin
                o_cmd.begin_op = 1'b1;
                case (i_sts.mode)
                    fts_pkg::MODE_CREATE: ;
                    fts_pkg::MODE_YIELD: begin
                        if (!i_sts.tgt_range_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = fts_pkg::ST_RANGE;
                        end else if (!i_sts.tgt_valid) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = fts_pkg::ST_INVALID;
                        end else begin
                            o_cmd.set_prev    = 1'b1;
                            o_cmd.take_target = 1'b1;
                        end
                    end
                    fts_pkg::MODE_SCHED: o_cmd.set_prev = !i_sts.count_zero;
                    default: begin
                        o_cmd.set_prev = 1'b1;
                        o_cmd.free_cur = i_sts.present;
                    end
                endcase
            end
            fts_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.key       = fts_pkg::KEY_SCAN;
                if (!i_sts.scan_hit && i_sts.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = fts_pkg::ST_NO_FREE;
                end
            end
            fts_pkg::S_DROP_OLD: begin
                o_cmd.drop = 1'b1;
                o_cmd.key  = fts_pkg::KEY_OLD;
            end
            fts_pkg::S_DROP_TGT: begin
                o_cmd.drop = 1'b1;
                o_cmd.key  = fts_pkg::KEY_TGT;
            end
            fts_pkg::S_APPEND_OLD: begin
                o_cmd.append = 1'b1;
                o_cmd.key    = fts_pkg::KEY_OLD;
            end
            fts_pkg::S_POP: o_cmd.pop = !i_sts.count_zero;
            fts_pkg::S_OUT: o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_stall = (r_state != fts_pkg::S_IDLE);
    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

/* rtl/fts_dp.sv */
// scheduler datapath: slot valid bits, ready queue, running thread, result register
`default_nettype none

module fts_dp #(
    parameter int THREAD_SLOTS = fts_pkg::THREAD_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fts_pkg::t_in  i_data,
    input  wire fts_pkg::t_cmd i_cmd,
    output fts_pkg::t_sts      o_sts,
    output fts_pkg::t_out      o_data
);

    localparam int IW = $clog2(THREAD_SLOTS);
    localparam int CW = $clog2(THREAD_SLOTS + 1);

    logic [1:0]          r_mode;
    logic signed [7:0]   r_target;
    logic [THREAD_SLOTS-1:0] r_valid, n_valid;
    logic [IW-1:0]       r_q [THREAD_SLOTS];
    logic [IW-1:0]       n_q [THREAD_SLOTS];
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_cur, n_cur;
    logic                r_present, n_present;
    logic [IW-1:0]       r_search, n_search;
    logic [IW-1:0]       r_old, n_old;
    logic                r_had, n_had;
    logic [IW-1:0]       r_prev, n_prev;
    logic [IW-1:0]       r_created, n_created;
    logic [1:0]          r_status, n_status;
    logic [IW-1:0]       r_ptr, n_ptr;
    logic [IW-1:0]       r_scan, n_scan;
    logic [CW-1:0]       r_step, n_step;
    logic                r_found, n_found;
    fts_pkg::t_out       r_out, n_out;

    logic [IW-1:0]       key;
    logic [IW-1:0]       head;
    logic [CW-1:0]       tail_full;
    logic [IW-1:0]       tail;
    logic                drop_done;
    logic                range_ok;
    logic                scan_hit;
    logic                do_append;

    always_comb begin
        case (i_cmd.key)
            fts_pkg::KEY_OLD:  key = r_old;
            fts_pkg::KEY_TGT:  key = r_target[IW-1:0];
            fts_pkg::KEY_SCAN: key = r_ptr;
            default:           key = r_old;
        endcase
    end

    assign head      = r_q[0];
    assign tail_full = r_count - CW'(1) - CW'(r_found);
    assign tail      = tail_full[IW-1:0];
    assign drop_done = (r_step == r_count);
    assign range_ok  = !r_target[7] && ({1'b0, r_target[6:0]} < 8'(THREAD_SLOTS));
    assign scan_hit  = !r_valid[r_ptr];
    assign do_append = i_cmd.append || (i_cmd.scan_step && scan_hit);

    always_comb begin
        n_valid   = r_valid;
        n_q       = r_q;
        n_count   = r_count;
        n_cur     = r_cur;
        n_present = r_present;
        n_search  = r_search;
        n_old     = r_old;
        n_had     = r_had;
        n_prev    = r_prev;
        n_created = r_created;
        n_status  = r_status;
        n_ptr     = r_ptr;
        n_scan    = r_scan;
        n_step    = r_step;
        n_found   = r_found;
        n_out     = r_out;

        if (i_cmd.begin_op) begin
            n_old     = r_cur;
            n_had     = r_present;
            n_prev    = '0;
            n_created = '0;
            n_status  = fts_pkg::ST_OK;
            n_ptr     = r_search;
            n_scan    = '0;
        end
        if (i_cmd.set_prev) n_prev = r_present ? r_cur : '0;
        if (i_cmd.set_status) n_status = i_cmd.status;
        if (i_cmd.take_target) begin
            n_cur     = r_target[IW-1:0];
            n_present = 1'b1;
        end
        if (i_cmd.free_cur) begin
            n_valid[r_cur] = 1'b0;
            n_present      = 1'b0;
            n_cur          = '0;
        end

        // slot search, one slot a cycle from the rotating pointer
        if (i_cmd.scan_step) begin
            if (scan_hit) begin
                n_valid[r_ptr] = 1'b1;
                n_search       = r_ptr;
                n_created      = r_ptr;
            end else begin
                n_ptr  = (r_ptr == IW'(THREAD_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                n_scan = r_scan + 1'b1;
            end
        end

        // drop pass: rotate the queue once, leaving out the first match
        if (i_cmd.drop) begin
            if (!drop_done) begin
                for (int k = 0; k < THREAD_SLOTS - 1; k++) begin
                    n_q[k] = r_q[k+1];
                end
                if (head == key && !r_found) begin
                    n_found = 1'b1;
                end else begin
                    n_q[tail] = head;
                end
                n_step = r_step + 1'b1;
            end else begin
                n_count = r_count - CW'(r_found);
                n_step  = '0;
                n_found = 1'b0;
            end
        end

        if (do_append && (r_count < CW'(THREAD_SLOTS))) begin
            n_q[r_count[IW-1:0]] = key;
            n_count              = r_count + 1'b1;
        end

        if (i_cmd.pop) begin
            for (int k = 0; k < THREAD_SLOTS - 1; k++) begin
                n_q[k] = r_q[k+1];
            end
            n_count   = r_count - 1'b1;
            n_cur     = head;
            n_present = 1'b1;
        end

        if (i_cmd.load_out) begin
            n_out.status          = r_status;
            n_out.running_thread  = r_present ? 6'(r_cur) : '0;
            n_out.running_present = r_present;
            n_out.previous_thread = 6'(r_prev);
            n_out.created_thread  = 6'(r_created);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= THREAD_SLOTS'(1);
            r_count   <= '0;
            r_cur     <= '0;
            r_present <= 1'b1;
            r_search  <= '0;
            r_step    <= '0;
            r_found   <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_present <= n_present;
            r_search  <= n_search;
            r_step    <= n_step;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_data.mode;
            r_target <= i_data.target_thread;
        end
        r_q       <= n_q;
        r_old     <= n_old;
        r_had     <= n_had;
        r_prev    <= n_prev;
        r_created <= n_created;
        r_status  <= n_status;
        r_ptr     <= n_ptr;
        r_scan    <= n_scan;
        r_out     <= n_out;
    end

    assign o_sts.mode         = r_mode;
    assign o_sts.had          = r_had;
    assign o_sts.present      = r_present;
    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.tgt_range_ok = range_ok;
    assign o_sts.tgt_valid    = range_ok && r_valid[r_target[IW-1:0]];
    assign o_sts.scan_hit     = scan_hit;
    assign o_sts.scan_last    = (r_scan == IW'(THREAD_SLOTS - 1));
    assign o_sts.drop_done    = drop_done;

    assign o_data = r_out;

endmodule

`default_nettype wire

/* rtl/fts_checker.sv */
// port-level checks of the thread scheduler, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module fts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire fts_pkg::t_out o_data
);

    // coming out of reset the block is idle with nothing to deliver
    `FTS_ASSERT_SAME(a_reset_idle, $past(!i_rst_n), !o_valid && !o_stall)

    // an accepted beat keeps the block busy in the next cycle
    `FTS_ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, o_stall)

    // a stalled result beat stays and holds its payload
    `FTS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))

    // a failed operation switches nothing and creates nothing
    `FTS_ASSERT_SAME(a_err_quiet, o_valid && (o_data.status != fts_pkg::ST_OK),
        (o_data.previous_thread == '0) && (o_data.created_thread == '0))

endmodule

bind fifo_thread_scheduler_top fts_checker u_fts_checker (.*);

`default_nettype wire
